// ===== design/sppa_pkg.sv =====
package sppa_pkg;

   // Command codes carried in a request.
   typedef enum logic [2:0] {
      CMD_ALLOC           = 3'd0,
      CMD_FREE            = 3'd1,
      CMD_CHECK_WRITE     = 3'd2,
      CMD_HOLD            = 3'd3,
      CMD_TPA_SWAP        = 3'd4,
      CMD_RELEASE_PROCESS = 3'd5,
      CMD_RELEASE_ALL     = 3'd6,
      CMD_TPA_RESTORE     = 3'd7
   } cmd_type;

   // Result kinds.
   localparam logic KIND_MAP   = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   // Supervisor stack segment and the owner code of a free slot.
   localparam logic [6:0] STACK_SEG  = 7'h3F;
   localparam logic [7:0] OWNER_FREE = 8'h00;

   typedef struct packed {
      cmd_type     cmd;
      logic [6:0]  segment;
      logic [6:0]  process;
      logic [15:0] offset;
      logic [15:0] length;
      logic [15:0] low_bound;
      logic [15:0] stack_top;
      logic        hold_on;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [6:0] map_segment;
      logic [7:0] map_page;
      logic       map_system_only;
      logic [6:0] reply_value;
      logic [5:0] free_count;
      logic       last;
   } rsp_type;

   // One slot as stored in the slot memory.
   typedef struct packed {
      logic [7:0] owner;
      logic       held;
      logic [7:0] page;
   } slot_entry_type;

   // Command sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_SINGLE_RD,
      S_SINGLE_EX,
      S_SWAP2,
      S_ALLOC,
      S_HOME,
      S_RST1,
      S_RST2,
      S_RELEASE,
      S_COUNT,
      S_REPLY
   } state_type;

endpackage

// ===== design/segment_page_pool_allocator.sv =====
// Segment page pool allocator.
// A request is taken on start while busy is low; busy stays high until the
// command is finished. The block answers with a train of results, each on
// rsp_payload for one cycle while rsp_valid is high: first every mapping
// change the command makes (kind 0), then one reply (kind 1, last set) with
// the reply value and the number of free active slots.
// The receiver cannot stall; results are simply presented as the command produces them.
// Slot state lives in one slot memory with a registered read, and
// every command walks it through a single read port.
// Only one command is in work at a time.
// csr_we writes the slots_available register; the user must write it only while idle, as the block does not enforce it.
// After reset all slots are free, each slot points at POOL_BASE_PAGE plus its
// index, the program area sits on TPA_HOME_PAGE and no slot is available.
// Unwritten slots read as their reset value through per-slot valid bits, so
// no clearing pass is needed.
module segment_page_pool_allocator
   import sppa_pkg::*;
#(
   parameter int SLOTS          = 16,
   parameter int SEG_LOW        = 64,
   parameter int UP_SLOTS       = 8,
   parameter int POOL_BASE_PAGE = 8,
   parameter int TPA_SEG        = 2,
   parameter int TPA_HOME_PAGE  = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_payload,
   output logic       rsp_valid,
   output rsp_type    rsp_payload,
   input  logic       csr_we,
   input  logic [5:0] csr_wdata
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [7:0] HOME_PAGE = 8'(TPA_HOME_PAGE);
   localparam logic [6:0] TPA_SEGMENT = 7'(TPA_SEG);

   state_type      state_ff, state_in;
   req_type        req_ff, req_in;
   logic [5:0]     avail_ff, avail_in;
   logic [7:0]     tpa_ff, tpa_in;
   logic [CW-1:0]  rd_idx_ff, rd_idx_in;
   logic           rd_vld_ff, rd_vld_in;
   logic [IW-1:0]  dat_idx_ff, dat_idx_in;
   logic [SLOTS-1:0] written_ff, written_in;
   logic [6:0]     reply_ff, reply_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           held_any_ff, held_any_in;
   logic           found_ff, found_in;
   logic [IW-1:0]  fidx_ff, fidx_in;
   slot_entry_type fent_ff, fent_in;
   logic [7:0]     aux_ff, aux_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic           ram_we;
   logic [IW-1:0]  ram_waddr, ram_raddr;
   slot_entry_type ram_wdata, ram_q, rd_ent;

   logic [CW-1:0]  act;
   logic [7:0]     me;
   logic           seg_ok;
   logic [IW-1:0]  seg_idx;
   logic [7:0]     seg8, seg_i;
   logic           check_ok;
   logic           scan_issue, scan_done, in_scan;

   // Logical segment that a slot stands for.
   function automatic logic [6:0] seg_of_slot(input logic [IW-1:0] idx);
      logic [7:0] i8;
      logic [7:0] s;
      i8 = 8'(idx);
      if (i8 < 8'(UP_SLOTS)) begin
         s = 8'(SEG_LOW) + i8;
      end else begin
         s = 8'(SEG_LOW - 1 + UP_SLOTS) - i8;
      end
      return s[6:0];
   endfunction

   // Mapping result.
   function automatic rsp_type map_rsp(input logic [6:0] seg, input logic [7:0] page,
                                       input logic sys);
      rsp_type r;
      r = '0;
      r.kind = KIND_MAP;
      r.map_segment = seg;
      r.map_page = page;
      r.map_system_only = sys;
      return r;
   endfunction

   // Slot memory.
   sppa_ram #(
      .WIDTH($bits(slot_entry_type)),
      .DEPTH(SLOTS)
   ) u_slot_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_q)
   );

   // Active slot count and owner code of the caller.
   assign act = (avail_ff > 6'(SLOTS)) ? CW'(SLOTS) : CW'(avail_ff);
   assign me  = 8'({1'b0, req_ff.process}) + 8'd1;

   // Read data, with never-written slots showing their reset contents.
   always_comb begin
      if (written_ff[dat_idx_ff]) begin
         rd_ent = ram_q;
      end else begin
         rd_ent.owner = OWNER_FREE;
         rd_ent.held  = 1'b0;
         rd_ent.page  = 8'(POOL_BASE_PAGE + int'(dat_idx_ff));
      end
   end

   // Map the requested segment onto an active slot.
   always_comb begin
      seg8 = {1'b0, req_ff.segment};
      if (seg8 >= 8'(SEG_LOW)) begin
         seg_i  = seg8 - 8'(SEG_LOW);
         seg_ok = (seg_i < 8'(UP_SLOTS));
      end else begin
         seg_i  = 8'(UP_SLOTS + SEG_LOW - 1) - seg8;
         seg_ok = 1'b1;
      end
      seg_ok  = seg_ok && (seg_i < 8'(act));
      seg_idx = seg_i[IW-1:0];
   end

   // Write permission check.
   always_comb begin
      if (req_ff.segment == TPA_SEGMENT) begin
         check_ok = 1'b1;
      end else if (req_ff.segment == STACK_SEG) begin
         check_ok = (req_ff.offset >= req_ff.low_bound) &&
                    (req_ff.offset <= req_ff.stack_top) &&
                    (req_ff.length <= (req_ff.stack_top - req_ff.offset));
      end else begin
         check_ok = seg_ok && (rd_ent.owner == me);
      end
   end

   // Walk over the active slots: one read issued per cycle.
   assign in_scan    = (state_ff == S_ALLOC) || (state_ff == S_HOME) ||
                       (state_ff == S_RELEASE) || (state_ff == S_COUNT);
   assign scan_issue = (rd_idx_ff < act);
   assign scan_done  = !scan_issue && !rd_vld_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_payload.cmd)
                  CMD_ALLOC:           state_in = S_ALLOC;
                  CMD_FREE,
                  CMD_CHECK_WRITE,
                  CMD_HOLD,
                  CMD_TPA_SWAP:        state_in = S_SINGLE_RD;
                  CMD_RELEASE_PROCESS: state_in = S_RELEASE;
                  CMD_RELEASE_ALL:     state_in = S_HOME;
                  CMD_TPA_RESTORE:     state_in = (tpa_ff == HOME_PAGE) ? S_COUNT : S_HOME;
               endcase
            end
         end
         S_SINGLE_RD: state_in = S_SINGLE_EX;
         S_SINGLE_EX: begin
            if (req_ff.cmd == CMD_TPA_SWAP && seg_ok && rd_ent.owner != OWNER_FREE) begin
               state_in = S_SWAP2;
            end else begin
               state_in = S_COUNT;
            end
         end
         S_SWAP2: state_in = S_COUNT;
         S_ALLOC: begin
            if ((rd_vld_ff && rd_ent.owner == OWNER_FREE) || scan_done) begin
               state_in = S_COUNT;
            end
         end
         S_HOME: begin
            if (scan_done) begin
               if (found_ff && tpa_ff != HOME_PAGE &&
                   (req_ff.cmd == CMD_TPA_RESTORE || !held_any_ff)) begin
                  state_in = S_RST1;
               end else if (req_ff.cmd == CMD_RELEASE_ALL) begin
                  state_in = S_RELEASE;
               end else begin
                  state_in = S_COUNT;
               end
            end
         end
         S_RST1: state_in = S_RST2;
         S_RST2: state_in = (req_ff.cmd == CMD_RELEASE_ALL) ? S_RELEASE : S_COUNT;
         S_RELEASE: begin
            if (scan_done) begin
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            if (scan_done) begin
               state_in = S_REPLY;
            end
         end
         S_REPLY: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath, memory accesses and result generation.
   always_comb begin
      req_in       = req_ff;
      avail_in     = csr_we ? csr_wdata : avail_ff;
      tpa_in       = tpa_ff;
      reply_in     = reply_ff;
      cnt_in       = cnt_ff;
      held_any_in  = held_any_ff;
      found_in     = found_ff;
      fidx_in      = fidx_ff;
      fent_in      = fent_ff;
      aux_in       = aux_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = dat_idx_ff;
      ram_wdata    = rd_ent;
      ram_raddr    = rd_idx_ff[IW-1:0];
      dat_idx_in   = rd_idx_ff[IW-1:0];
      rd_idx_in    = rd_idx_ff;
      rd_vld_in    = 1'b0;

      if (in_scan) begin
         rd_vld_in = scan_issue;
         rd_idx_in = rd_idx_ff + CW'(scan_issue);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in      = req_payload;
               reply_in    = '0;
               found_in    = 1'b0;
               held_any_in = 1'b0;
            end
         end
         S_SINGLE_RD: begin
            ram_raddr  = seg_idx;
            dat_idx_in = seg_idx;
         end
         S_SINGLE_EX: begin
            unique case (req_ff.cmd)
               CMD_FREE: begin
                  if (seg_ok && rd_ent.owner != OWNER_FREE) begin
                     ram_we          = 1'b1;
                     ram_wdata.owner = OWNER_FREE;
                     ram_wdata.held  = 1'b0;
                     rsp_valid_in    = 1'b1;
                     rsp_in          = map_rsp(req_ff.segment, rd_ent.page, 1'b1);
                     reply_in        = 7'd1;
                  end
               end
               CMD_CHECK_WRITE: begin
                  reply_in = {6'b0, check_ok};
               end
               CMD_HOLD: begin
                  if (seg_ok && rd_ent.owner != OWNER_FREE) begin
                     ram_we         = 1'b1;
                     ram_wdata.held = req_ff.hold_on;
                     reply_in       = 7'd1;
                  end
               end
               CMD_TPA_SWAP: begin
                  if (seg_ok && rd_ent.owner != OWNER_FREE) begin
                     ram_we         = 1'b1;
                     ram_wdata.page = tpa_ff;
                     tpa_in         = rd_ent.page;
                     aux_in         = tpa_ff;
                     rsp_valid_in   = 1'b1;
                     rsp_in         = map_rsp(TPA_SEGMENT, rd_ent.page, 1'b0);
                     reply_in       = 7'd1;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SWAP2: begin
            rsp_valid_in = 1'b1;
            rsp_in       = map_rsp(req_ff.segment, aux_ff, 1'b0);
         end
         S_ALLOC: begin
            // Take the first free slot found.
            if (rd_vld_ff && rd_ent.owner == OWNER_FREE) begin
               ram_we          = 1'b1;
               ram_wdata.owner = me;
               rsp_valid_in    = 1'b1;
               rsp_in          = map_rsp(seg_of_slot(dat_idx_ff), rd_ent.page, 1'b0);
               reply_in        = seg_of_slot(dat_idx_ff);
            end
         end
         S_HOME: begin
            // Look for held owned slots and the first slot on the home page.
            if (rd_vld_ff) begin
               if (rd_ent.owner != OWNER_FREE && rd_ent.held) begin
                  held_any_in = 1'b1;
               end
               if (!found_ff && rd_ent.page == HOME_PAGE) begin
                  found_in = 1'b1;
                  fidx_in  = dat_idx_ff;
                  fent_in  = rd_ent;
               end
            end
         end
         S_RST1: begin
            ram_we          = 1'b1;
            ram_waddr       = fidx_ff;
            ram_wdata.owner = fent_ff.owner;
            ram_wdata.held  = fent_ff.held;
            ram_wdata.page  = tpa_ff;
            tpa_in          = HOME_PAGE;
            aux_in          = tpa_ff;
            rsp_valid_in    = 1'b1;
            rsp_in          = map_rsp(TPA_SEGMENT, HOME_PAGE, 1'b0);
            if (req_ff.cmd == CMD_TPA_RESTORE) begin
               reply_in = 7'd1;
            end
         end
         S_RST2: begin
            rsp_valid_in = 1'b1;
            rsp_in       = map_rsp(seg_of_slot(fidx_ff), aux_ff,
                                   fent_ff.owner == OWNER_FREE);
         end
         S_RELEASE: begin
            // Free every unheld slot of the caller.
            if (rd_vld_ff && rd_ent.owner == me && !rd_ent.held) begin
               ram_we          = 1'b1;
               ram_wdata.owner = OWNER_FREE;
               ram_wdata.held  = 1'b0;
               rsp_valid_in    = 1'b1;
               rsp_in          = map_rsp(seg_of_slot(dat_idx_ff), rd_ent.page, 1'b1);
            end
         end
         S_COUNT: begin
            if (rd_vld_ff && rd_ent.owner == OWNER_FREE) begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_REPLY: begin
            rsp_valid_in           = 1'b1;
            rsp_in                 = '0;
            rsp_in.kind            = KIND_REPLY;
            rsp_in.reply_value     = reply_ff;
            rsp_in.free_count      = 6'(cnt_ff);
            rsp_in.last            = 1'b1;
         end
         default: begin
         end
      endcase

      // Every walk starts over from slot zero; reads still in flight are dropped.
      if (state_in != state_ff) begin
         rd_idx_in = '0;
         rd_vld_in = 1'b0;
         if (state_in == S_COUNT) begin
            cnt_in = '0;
         end
      end

      written_in = written_ff;
      if (ram_we) begin
         written_in[ram_waddr] = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         avail_ff     <= '0;
         tpa_ff       <= HOME_PAGE;
         written_ff   <= '0;
         rd_idx_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         avail_ff     <= avail_in;
         tpa_ff       <= tpa_in;
         written_ff   <= written_in;
         rd_idx_ff    <= rd_idx_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      dat_idx_ff  <= dat_idx_in;
      reply_ff    <= reply_in;
      cnt_ff      <= cnt_in;
      held_any_ff <= held_any_in;
      found_ff    <= found_in;
      fidx_ff     <= fidx_in;
      fent_ff     <= fent_in;
      aux_ff      <= aux_in;
      rsp_ff      <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // Mapping results appear only while a command is still in work.
   a_map_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |-> busy)
      else $error("mapping result outside a command");

   // The reply closes a command and is never followed at once by another result.
   a_reply_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last |=> !rsp_valid)
      else $error("result right after a reply");

   // An accepted request makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but block not busy");

   // A walk never writes the slot it is reading in the same cycle.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      in_scan && ram_we && scan_issue |-> ram_waddr != ram_raddr)
      else $error("slot memory read and write collide");

   // The free count never exceeds the pool size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_REPLY |-> rsp_payload.free_count <= 6'(SLOTS))
      else $error("free count out of range");
`endif

endmodule

// ===== design/sppa_ram.sv =====
module sppa_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
